### rtl/ndms_pkg.sv
// shared types and constants of the nearest display mode selector
package ndms_pkg;

    localparam int MODE_W    = 14;
    localparam int IDX_W     = 8;
    localparam int CFG_IDX_W = 3;
    localparam int Q_DEPTH   = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TARGET_W = 3'd0,
        CFG_TARGET_H = 3'd1,
        CFG_RATIO_W  = 3'd2,
        CFG_RATIO_H  = 3'd3,
        CFG_LIMIT_W  = 3'd4,
        CFG_LIMIT_H  = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [MODE_W-1:0] target_width;
        logic [MODE_W-1:0] target_height;
        logic [MODE_W-1:0] ratio_ref_width;
        logic [MODE_W-1:0] ratio_ref_height;
        logic [MODE_W-1:0] limit_width;
        logic [MODE_W-1:0] limit_height;
    } t_cfg;

    typedef struct packed {
        logic [MODE_W-1:0] mode_width;
        logic [MODE_W-1:0] mode_height;
        logic              mode_ok;
        logic              last_mode;
        logic              over_limit;
    } t_entry;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_REF_DIV,
        ST_MODE_DIV,
        ST_EVAL
    } t_back_state;

endpackage

### rtl/ndms_mode_if.sv
// candidate mode channel: valid, ready and one mode item
interface ndms_mode_if;
    import ndms_pkg::*;

    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode_width;
    logic [MODE_W-1:0] mode_height;
    logic              mode_ok;
    logic              last_mode;

    modport source (
        output valid, mode_width, mode_height, mode_ok, last_mode,
        input  ready
    );
    modport sink (
        input  valid, mode_width, mode_height, mode_ok, last_mode,
        output ready
    );
endinterface

### rtl/ndms_result_if.sv
// result channel: valid, ready and one selection result item
interface ndms_result_if;
    import ndms_pkg::*;

    logic              valid;
    logic              ready;
    logic              found;
    logic [IDX_W-1:0]  best_index;
    logic [MODE_W-1:0] best_width;
    logic [MODE_W-1:0] best_height;

    modport source (
        output valid, found, best_index, best_width, best_height,
        input  ready
    );
    modport sink (
        input  valid, found, best_index, best_width, best_height,
        output ready
    );
endinterface

### rtl/ndms_front.sv
// front end: takes mode items, checks the size bounds, pushes into the queue
module ndms_front (
    ndms_mode_if.sink        i_mode,
    input  ndms_pkg::t_cfg   i_cfg,
    input  logic             i_full,
    output logic             o_push,
    output ndms_pkg::t_entry o_entry
);
    import ndms_pkg::*;

    logic over_w;
    logic over_h;

    assign over_w = (i_cfg.limit_width != '0) && (i_mode.mode_width > i_cfg.limit_width);
    assign over_h = (i_cfg.limit_height != '0) && (i_mode.mode_height > i_cfg.limit_height);

    assign i_mode.ready = !i_full;
    assign o_push       = i_mode.valid && !i_full;

    always_comb begin
        o_entry.mode_width  = i_mode.mode_width;
        o_entry.mode_height = i_mode.mode_height;
        o_entry.mode_ok     = i_mode.mode_ok;
        o_entry.last_mode   = i_mode.last_mode;
        o_entry.over_limit  = over_w || over_h;
    end
endmodule

### rtl/ndms_queue.sv
// short queue of classified mode items between front and back
module ndms_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  ndms_pkg::t_entry i_entry,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_empty,
    output ndms_pkg::t_entry o_entry
);
    import ndms_pkg::*;

    localparam int PTR_W = $clog2(Q_DEPTH);

    t_entry           r_slot [Q_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [PTR_W:0]   r_count;

    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [PTR_W:0]   n_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == (PTR_W+1)'(Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_entry = r_slot[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_entry;
        end
    end
endmodule

### rtl/ndms_div.sv
// restoring divider, one quotient bit per cycle, for the fixed-point ratio
module ndms_div #(
    parameter int FRAC = 10
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic [ndms_pkg::MODE_W+FRAC-1:0]     i_dividend,
    input  logic [ndms_pkg::MODE_W-1:0]          i_divisor,
    output logic                                 o_done,
    output logic [ndms_pkg::MODE_W+FRAC-1:0]     o_quotient
);
    import ndms_pkg::*;

    localparam int DW = MODE_W + FRAC;
    localparam int CW = $clog2(DW + 1);

    logic              r_busy;
    logic              r_done;
    logic [CW-1:0]     r_cnt;
    logic [MODE_W-1:0] r_rem;
    logic [MODE_W-1:0] r_div;
    logic [DW-1:0]     r_quo;

    logic [MODE_W:0]   trial;
    logic              fits;
    logic [MODE_W:0]   diff;

    assign trial = {r_rem, r_quo[DW-1]};
    assign fits  = (trial >= {1'b0, r_div});
    assign diff  = trial - {1'b0, r_div};

    assign o_done     = r_done;
    assign o_quotient = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_div <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= fits ? diff[MODE_W-1:0] : trial[MODE_W-1:0];
            r_quo <= {r_quo[DW-2:0], fits};
        end
    end
endmodule

### rtl/ndms_back.sv
// back end: ratio filter, best-match tracking and the result register
module ndms_back #(
    parameter int RATIO_FRAC_BITS = 10,
    parameter int MAX_MODES       = 256
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  ndms_pkg::t_cfg   i_cfg,
    input  logic             i_ratio_wr,
    input  logic             i_empty,
    input  ndms_pkg::t_entry i_entry,
    output logic             o_pop,
    ndms_result_if.source    o_res
);
    import ndms_pkg::*;

    localparam int DW = MODE_W + RATIO_FRAC_BITS;
    localparam int PW = $clog2(MAX_MODES);

    t_back_state       r_state, n_state;
    t_entry            r_cur;
    logic [PW-1:0]     r_pos, n_pos;
    logic [MODE_W-1:0] r_cw, n_cw;
    logic [MODE_W-1:0] r_ch, n_ch;
    logic [MODE_W-1:0] r_cwg, n_cwg;
    logic [MODE_W-1:0] r_chg, n_chg;
    logic [PW-1:0]     r_cpos, n_cpos;
    logic              r_locked, n_locked;
    logic              r_pass, n_pass;
    logic [DW-1:0]     r_want, n_want;
    logic              r_want_ok, n_want_ok;

    logic              r_out_valid, n_out_valid;
    logic              r_out_found, n_out_found;
    logic [IDX_W-1:0]  r_out_idx, n_out_idx;
    logic [MODE_W-1:0] r_out_w, n_out_w;
    logic [MODE_W-1:0] r_out_h, n_out_h;

    logic              div_start;
    logic              div_ref;
    logic [DW-1:0]     div_dividend;
    logic [MODE_W-1:0] div_divisor;
    logic              div_done;
    logic [DW-1:0]     div_quo;

    logic              filter_on;
    logic              consider;
    logic              exact;
    logic [MODE_W-1:0] dw;
    logic [MODE_W-1:0] dh;
    logic              tie_w;
    logic              tie_h;
    logic              take;
    logic              can_emit;

    assign div_dividend = div_ref ? {i_cfg.ratio_ref_height, {RATIO_FRAC_BITS{1'b0}}}
                                  : {r_cur.mode_height, {RATIO_FRAC_BITS{1'b0}}};
    assign div_divisor  = div_ref ? i_cfg.ratio_ref_width : r_cur.mode_width;

    ndms_div #(
        .FRAC(RATIO_FRAC_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    assign filter_on = (i_cfg.ratio_ref_width != '0) && (i_cfg.ratio_ref_height != '0);
    assign consider  = r_cur.mode_ok && !r_locked && !r_cur.over_limit;
    assign exact     = (r_cur.mode_width == i_cfg.target_width)
                    && (r_cur.mode_height == i_cfg.target_height);
    assign dw = (r_cur.mode_width > i_cfg.target_width)
              ? r_cur.mode_width - i_cfg.target_width
              : i_cfg.target_width - r_cur.mode_width;
    assign dh = (r_cur.mode_height > i_cfg.target_height)
              ? r_cur.mode_height - i_cfg.target_height
              : i_cfg.target_height - r_cur.mode_height;
    assign tie_w = (dw == r_cwg) && (r_cw < i_cfg.target_width);
    assign tie_h = (dh == r_chg) && (r_ch < i_cfg.target_height);
    assign take  = (r_cw == '0)
                || (((dw < r_cwg) || tie_w) && (dh <= r_chg))
                || (((dh < r_chg) || tie_h) && (dw <= r_cwg));
    assign can_emit = !r_out_valid || o_res.ready;

    always_comb begin
        n_state     = r_state;
        n_pos       = r_pos;
        n_cw        = r_cw;
        n_ch        = r_ch;
        n_cwg       = r_cwg;
        n_chg       = r_chg;
        n_cpos      = r_cpos;
        n_locked    = r_locked;
        n_pass      = r_pass;
        n_want      = r_want;
        n_want_ok   = r_want_ok;
        n_out_valid = r_out_valid && !o_res.ready;
        n_out_found = r_out_found;
        n_out_idx   = r_out_idx;
        n_out_w     = r_out_w;
        n_out_h     = r_out_h;
        o_pop       = 1'b0;
        div_start   = 1'b0;
        div_ref     = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (!i_empty) begin
                    o_pop   = 1'b1;
                    n_state = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (!consider) begin
                    n_pass  = 1'b0;
                    n_state = ST_EVAL;
                end else if (!filter_on) begin
                    n_pass  = 1'b1;
                    n_state = ST_EVAL;
                end else if (!r_want_ok) begin
                    div_start = 1'b1;
                    div_ref   = 1'b1;
                    n_state   = ST_REF_DIV;
                end else if (r_want == '0) begin
                    // reference ratio truncates to zero: filter stays off
                    n_pass  = 1'b1;
                    n_state = ST_EVAL;
                end else if (r_cur.mode_width == '0) begin
                    n_pass  = 1'b0;
                    n_state = ST_EVAL;
                end else begin
                    div_start = 1'b1;
                    n_state   = ST_MODE_DIV;
                end
            end
            ST_REF_DIV: begin
                if (div_done) begin
                    n_want    = div_quo;
                    n_want_ok = 1'b1;
                    n_state   = ST_DECIDE;
                end
            end
            ST_MODE_DIV: begin
                if (div_done) begin
                    n_pass  = (div_quo == r_want);
                    n_state = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (!r_cur.last_mode || can_emit) begin
                    if (r_pass) begin
                        if (exact) begin
                            n_cw     = r_cur.mode_width;
                            n_ch     = r_cur.mode_height;
                            n_cpos   = r_pos;
                            n_locked = 1'b1;
                        end else if (take) begin
                            n_cw   = r_cur.mode_width;
                            n_ch   = r_cur.mode_height;
                            n_cwg  = dw;
                            n_chg  = dh;
                            n_cpos = r_pos;
                        end
                    end
                    if (r_cur.last_mode) begin
                        n_out_valid = 1'b1;
                        n_out_found = (n_cw != '0) && (n_ch != '0);
                        n_out_idx   = n_out_found ? IDX_W'(n_cpos) : '0;
                        n_out_w     = n_out_found ? n_cw : '0;
                        n_out_h     = n_out_found ? n_ch : '0;
                        n_pos       = '0;
                        n_cw        = '0;
                        n_ch        = '0;
                        n_cwg       = '0;
                        n_chg       = '0;
                        n_cpos      = '0;
                        n_locked    = 1'b0;
                    end else begin
                        n_pos = (r_pos == PW'(MAX_MODES - 1)) ? '0 : r_pos + 1'b1;
                    end
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (i_ratio_wr) begin
            n_want_ok = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pos       <= '0;
            r_cw        <= '0;
            r_ch        <= '0;
            r_cwg       <= '0;
            r_chg       <= '0;
            r_cpos      <= '0;
            r_locked    <= 1'b0;
            r_pass      <= 1'b0;
            r_want_ok   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_cw        <= n_cw;
            r_ch        <= n_ch;
            r_cwg       <= n_cwg;
            r_chg       <= n_chg;
            r_cpos      <= n_cpos;
            r_locked    <= n_locked;
            r_pass      <= n_pass;
            r_want_ok   <= n_want_ok;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cur <= i_entry;
        end
        r_want      <= n_want;
        r_out_found <= n_out_found;
        r_out_idx   <= n_out_idx;
        r_out_w     <= n_out_w;
        r_out_h     <= n_out_h;
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.found       = r_out_found;
    assign o_res.best_index  = r_out_idx;
    assign o_res.best_width  = r_out_w;
    assign o_res.best_height = r_out_h;
endmodule

### rtl/nearest_display_mode_select_top.sv
// top level of the nearest display mode selector
// Candidate display modes come in one item each on i_mode; the block keeps the
// mode nearest to the configured target size and, on the item marked last_mode,
// sends one result item on o_result (found, list index, width, height) and then
// starts a fresh list. Unreadable modes, modes above the size limits and, when
// both ratio reference registers are nonzero, modes whose fixed-point
// height/width ratio differs from the reference are skipped, though each one
// still counts a list position. An exact match locks the choice for the rest of
// the list. A front end checks the limits and drops items into a two-entry
// queue; a back end runs the ratio filter and the comparison, and holds the
// result in an output register so the next list can start while it waits.
// Per item the back end steps through idle, decide and evaluate when the ratio
// filter is off or the item is skipped early, and through idle, decide, the
// mode division and evaluate when the ratio must be checked, the division run
// by the restoring divider that produces one quotient bit per cycle. The first
// filtered item after a write of either ratio reference register also waits
// while the reference ratio is divided out and cached.
// Configuration: write i_cfg_data to register i_cfg_index while i_cfg_we is
// high; 0 target width, 1 target height, 2 and 3 ratio reference width and
// height, 4 and 5 width and height limits (zero means no limit). Other
// indexes are ignored. Write only while the block is idle.
module nearest_display_mode_select_top #(
    parameter int RATIO_FRAC_BITS = 10,
    parameter int MAX_MODES       = 256
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    ndms_mode_if.sink                           i_mode,
    ndms_result_if.source                       o_result,
    input  logic                                i_cfg_we,
    input  logic [ndms_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [ndms_pkg::MODE_W-1:0]         i_cfg_data
);
    import ndms_pkg::*;

    // configuration registers, all cleared by reset
    t_cfg   r_cfg;
    logic   ratio_wr;

    // front to queue, queue to back
    logic   push;
    t_entry push_entry;
    logic   q_full;
    logic   q_empty;
    logic   pop;
    t_entry pop_entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_TARGET_W: r_cfg.target_width     <= i_cfg_data;
                CFG_TARGET_H: r_cfg.target_height    <= i_cfg_data;
                CFG_RATIO_W:  r_cfg.ratio_ref_width  <= i_cfg_data;
                CFG_RATIO_H:  r_cfg.ratio_ref_height <= i_cfg_data;
                CFG_LIMIT_W:  r_cfg.limit_width      <= i_cfg_data;
                CFG_LIMIT_H:  r_cfg.limit_height     <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // a new ratio reference invalidates the cached reference quotient
    assign ratio_wr = i_cfg_we && ((i_cfg_index == CFG_RATIO_W)
                                || (i_cfg_index == CFG_RATIO_H));

    ndms_front u_front (
        .i_mode  (i_mode),
        .i_cfg   (r_cfg),
        .i_full  (q_full),
        .o_push  (push),
        .o_entry (push_entry)
    );

    ndms_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_entry (pop_entry)
    );

    ndms_back #(
        .RATIO_FRAC_BITS (RATIO_FRAC_BITS),
        .MAX_MODES       (MAX_MODES)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_ratio_wr (ratio_wr),
        .i_empty    (q_empty),
        .i_entry    (pop_entry),
        .o_pop      (pop),
        .o_res      (o_result)
    );

    // no choice means an all-zero result
    a_not_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && !o_result.found |->
            o_result.best_width == '0 && o_result.best_height == '0
            && o_result.best_index == '0)
        else $error("result without a choice carries nonzero fields");

    // a chosen mode always has a real size
    a_found_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && o_result.found |->
            o_result.best_width != '0 && o_result.best_height != '0)
        else $error("chosen mode has zero width or height");

    // the reported index lies inside the list range
    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> (32'(o_result.best_index) < MAX_MODES))
        else $error("best index beyond list length");

    // the front never pushes an item or signals ready while the queue reports full
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_full |-> !push && !i_mode.ready)
        else $error("item pushed into a full queue");
endmodule
